>>> rtl/pgphdr_pkg.sv
// Shared types and constants for the packet header parser.
`timescale 1ns / 1ps

package pgphdr_pkg;

	typedef enum logic [2:0] {
		PH_TAG     = 3'b001,
		PH_LEAD    = 3'b010,
		PH_COLLECT = 3'b100
	} phase_t;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_ZERO   = 2'd1;
	localparam status_t ST_UNSUP  = 2'd2;
	localparam status_t ST_RANGE  = 2'd3;

	localparam logic [7:0] TAG_NEW_BIT   = 8'h40;
	localparam logic [7:0] TAG_NEW_TYPE  = 8'h3F;
	localparam logic [7:0] TAG_OLD_TYPE  = 8'h3C;
	localparam logic [7:0] TAG_OLD_LTYPE = 8'h03;
	localparam logic [7:0] LEN_TWO_LO    = 8'd192;
	localparam logic [7:0] LEN_PART_LO   = 8'd224;
	localparam logic [7:0] LEN_FIVE      = 8'd255;

	localparam logic [1:0] OLD_LEN1 = 2'd0;
	localparam logic [1:0] OLD_LEN2 = 2'd1;
	localparam logic [1:0] OLD_LEN4 = 2'd2;

	typedef struct packed {
		phase_t      phase;
		logic [2:0]  bytes_left;
		logic [31:0] length_accum;
		logic        format_flag;
		logic [5:0]  type_field;
		logic        two_octet_mode;
	} parse_state_t;

	typedef struct packed {
		logic        is_new_format;
		logic [5:0]  packet_type;
		logic [31:0] body_length;
		status_t     status;
	} hdr_result_t;

	localparam parse_state_t STATE_RESET = '{
		phase:          PH_TAG,
		bytes_left:     3'd0,
		length_accum:   32'd0,
		format_flag:    1'b0,
		type_field:     6'd0,
		two_octet_mode: 1'b0
	};

endpackage

>>> rtl/pgp_packet_header_parser.sv
// Top level: input beat register, header decode, result register.
// out_valid rises when the decode of a header's last beat is loaded into the result register.
// Throughput: one stream byte per cycle while the result side keeps up.
// A result holds in the output register until taken; one beat then waits and input stalls.
// Reset (arst_n low, asynchronous) empties both registers and returns to the tag phase.
`timescale 1ns / 1ps

module pgp_packet_header_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  stream_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_new_format,
	output logic [5:0]  packet_type,
	output logic [31:0] body_length,
	output logic [1:0]  status
);
	import pgphdr_pkg::*;

	logic         valid_s1;
	logic [7:0]   byte_s1;
	parse_state_t state_q;
	parse_state_t state_nxt;
	logic         done;
	hdr_result_t  res;
	logic         out_valid_q;
	hdr_result_t  result_q;
	logic         advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	pgphdr_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.nxt     (state_nxt),
		.done    (done),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			state_q     <= STATE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (valid_s1 && advance) begin
				state_q <= state_nxt;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && done;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			byte_s1 <= stream_byte;
		end
		if (advance) begin
			result_q <= res;
		end
	end

	assign out_valid     = out_valid_q;
	assign is_new_format = result_q.is_new_format;
	assign packet_type   = result_q.packet_type;
	assign body_length   = result_q.body_length;
	assign status        = result_q.status;

endmodule

>>> rtl/pgphdr_step.sv
// Per-beat header decode: next parser state and the finished header.
`timescale 1ns / 1ps

module pgphdr_step (
	input  pgphdr_pkg::parse_state_t cur,
	input  logic [7:0]               byte_in,
	output pgphdr_pkg::parse_state_t nxt,
	output logic                     done,
	output pgphdr_pkg::hdr_result_t  result
);
	import pgphdr_pkg::*;

	logic [31:0]  len;
	status_t      st;
	logic [31:0]  shifted;
	logic [16:0]  two_len;
	logic [2:0]   left_dec;

	assign shifted  = {cur.length_accum[23:0], byte_in};
	assign two_len  = {1'b0, cur.length_accum[7:0], 8'd0} + {9'd0, byte_in}
		+ {9'd0, LEN_TWO_LO};
	assign left_dec = (cur.bytes_left != 3'd0) ? cur.bytes_left - 3'd1 : 3'd0;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		len  = 32'd0;
		st   = ST_OK;
		case (cur.phase)
			PH_LEAD: begin
				if (byte_in < LEN_TWO_LO) begin
					done = 1'b1;
					len  = {24'd0, byte_in};
				end else if (byte_in < LEN_PART_LO) begin
					nxt.length_accum   = {24'd0, byte_in - LEN_TWO_LO};
					nxt.bytes_left     = 3'd1;
					nxt.two_octet_mode = 1'b1;
					nxt.phase          = PH_COLLECT;
				end else if (byte_in == LEN_FIVE) begin
					nxt.length_accum   = 32'd0;
					nxt.bytes_left     = 3'd4;
					nxt.two_octet_mode = 1'b0;
					nxt.phase          = PH_COLLECT;
				end else begin
					done = 1'b1;
					st   = ST_UNSUP;
				end
			end
			PH_COLLECT: begin
				if (cur.two_octet_mode) begin
					done = 1'b1;
					len  = {15'd0, two_len};
				end else begin
					nxt.length_accum = shifted;
					nxt.bytes_left   = left_dec;
					if (left_dec == 3'd0) begin
						done = 1'b1;
						len  = shifted;
					end
				end
			end
			default: begin
				// tag byte; bit 7 ignored
				nxt.length_accum   = 32'd0;
				nxt.two_octet_mode = 1'b0;
				if ((byte_in & TAG_NEW_BIT) != 8'd0) begin
					nxt.format_flag = 1'b1;
					nxt.type_field  = byte_in[5:0] & TAG_NEW_TYPE[5:0];
					nxt.bytes_left  = 3'd0;
					nxt.phase       = PH_LEAD;
				end else begin
					nxt.format_flag = 1'b0;
					nxt.type_field  = {2'd0, byte_in[5:2] & TAG_OLD_TYPE[5:2]};
					nxt.phase       = PH_COLLECT;
					case (byte_in[1:0] & TAG_OLD_LTYPE[1:0])
						OLD_LEN1: nxt.bytes_left = 3'd1;
						OLD_LEN2: nxt.bytes_left = 3'd2;
						OLD_LEN4: nxt.bytes_left = 3'd4;
						default: begin
							done = 1'b1;
							st   = ST_UNSUP;
						end
					endcase
				end
			end
		endcase

		result.is_new_format = nxt.format_flag;
		result.packet_type   = nxt.type_field;
		result.body_length   = len;
		result.status        = st;
		if (st == ST_UNSUP) begin
			result.body_length = 32'd0;
		end else if (len == 32'd0) begin
			result.status = ST_ZERO;
		end else if (len[31]) begin
			result.status = ST_RANGE;
		end

		if (done) begin
			nxt.phase          = PH_TAG;
			nxt.bytes_left     = 3'd0;
			nxt.length_accum   = 32'd0;
			nxt.two_octet_mode = 1'b0;
		end
	end

endmodule
